// ----- design/adcsm_pkg.sv -----
// Shared types and constants for the ADPCM command stream monitor.
// Used by the front, queue, back and top-level files; depends on nothing.
`default_nettype none

package adcsm_pkg;

	localparam int unsigned TableEntries = 32;
	localparam int unsigned QueueDepth   = 2;

	localparam logic [7:0]  OP_DECODE     = 8'd1;
	localparam logic [7:0]  OP_LOAD_BOOK  = 8'd11;
	localparam logic [3:0]  INIT_FLAG     = 4'h1;
	localparam logic [13:0] HARD_LIMIT    = 14'd8192;
	localparam logic [13:0] MAX_CMD_RESET = 14'd8192;

	// One decode command as classified by the front part.
	typedef struct packed {
		logic [31:0] list_number;
		logic [23:0] state_address;
		logic [31:0] book;
		logic [3:0]  flags;
		logic [11:0] count;
	} job_t;

	typedef struct packed {
		logic valid;
		job_t job;
	} job_beat_t;

endpackage

`default_nettype wire

// ----- design/adcsm_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module adcsm_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 32,
	localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- design/adcsm_front.sv -----
// Front part: accepts command beats, tracks lists, the command limit and
// the current book, and hands decode commands on. Depends on adcsm_pkg.
`default_nettype none

module adcsm_front (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic                 first_in_list,
	input  wire logic [31:0]          word_high,
	input  wire logic [31:0]          word_low,
	input  wire logic                 cfg_we,
	input  wire logic [13:0]          cfg_wdata,
	input  wire logic                 q_full,
	output adcsm_pkg::job_beat_t      job_push
);

	logic [13:0] max_cmd_q;
	logic [31:0] active_book_q;
	logic [31:0] list_q;
	logic [13:0] seen_q;

	logic        accept;
	logic [13:0] limit;
	logic [13:0] seen_base;
	logic [31:0] book_base;
	logic [31:0] list_now;
	logic        in_range;
	logic [7:0]  op;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign op       = word_high[31:24];

	always_comb begin
		limit     = (max_cmd_q > adcsm_pkg::HARD_LIMIT) ? adcsm_pkg::HARD_LIMIT : max_cmd_q;
		seen_base = first_in_list ? 14'd0 : seen_q;
		book_base = first_in_list ? 32'd0 : active_book_q;
		list_now  = first_in_list ? list_q + 32'd1 : list_q;
		in_range  = seen_base < limit;
	end

	always_comb begin
		job_push.valid             = accept && in_range && (op == adcsm_pkg::OP_DECODE);
		job_push.job.list_number   = list_now;
		job_push.job.state_address = word_high[23:0];
		job_push.job.book          = book_base;
		job_push.job.flags         = word_low[31:28];
		job_push.job.count         = word_low[27:16];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_cmd_q     <= adcsm_pkg::MAX_CMD_RESET;
			active_book_q <= '0;
			list_q        <= '0;
			seen_q        <= '0;
		end else begin
			if (cfg_we) begin
				max_cmd_q <= cfg_wdata;
			end
			if (accept) begin
				list_q <= list_now;
				// A command past the limit changes nothing beyond the list restart.
				if (in_range) begin
					seen_q        <= seen_base + 14'd1;
					active_book_q <= (op == adcsm_pkg::OP_LOAD_BOOK) ? word_low : book_base;
				end else begin
					seen_q        <= seen_base;
					active_book_q <= book_base;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ----- design/adcsm_queue.sv -----
// Short queue of decode jobs between the front and back parts.
// Depends on adcsm_pkg for the job type and depth.
`default_nettype none

module adcsm_queue (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire adcsm_pkg::job_beat_t push,
	output logic                      full,
	input  wire logic                 pop,
	output adcsm_pkg::job_beat_t      head
);

	localparam int unsigned Depth = adcsm_pkg::QueueDepth;
	localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW  = $clog2(Depth + 1);

	adcsm_pkg::job_t entries_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	logic do_push;
	logic do_pop;

	assign full       = (count_q == CntW'(Depth));
	assign do_push    = push.valid && !full;
	assign do_pop     = pop && (count_q != '0);
	assign head.valid = (count_q != '0);
	assign head.job   = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push.job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CntW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ----- design/adcsm_back.sv -----
// Back part: looks up the previous book per state address in the
// associative table, builds the decode event and updates the table.
// Depends on adcsm_pkg and adcsm_ram.
`default_nettype none

module adcsm_back #(
	parameter int unsigned TABLE_ENTRIES = adcsm_pkg::TableEntries
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire adcsm_pkg::job_beat_t head,
	output logic                      pop,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [31:0]               event_index,
	output logic [31:0]               list_number,
	output logic [23:0]               state_address,
	output logic [31:0]               book_address,
	output logic [31:0]               previous_book,
	output logic [3:0]                decode_flags,
	output logic                      init_bit,
	output logic [11:0]               sample_count,
	output logic                      suspect
);

	localparam int unsigned IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_MATCH = 4'b0010,
		S_READ  = 4'b0100,
		S_EMIT  = 4'b1000
	} back_state_t;

	back_state_t            state_q;
	adcsm_pkg::job_t        job_q;
	logic [23:0]            key_q [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [TABLE_ENTRIES-1:0] match_q;
	logic                   hit_q;
	logic [IdxW-1:0]        hit_idx_q;
	logic                   free_any_q;
	logic [IdxW-1:0]        free_idx_q;
	logic [31:0]            event_q;

	logic [TABLE_ENTRIES-1:0] match;
	logic [TABLE_ENTRIES-1:0] free;
	logic [TABLE_ENTRIES-1:0] free_low;
	logic [IdxW-1:0]        match_idx;
	logic [IdxW-1:0]        free_idx;
	logic [31:0]            ram_rdata;
	logic [31:0]            prev;
	logic                   init;
	logic                   load;
	logic                   tbl_we;
	logic [IdxW-1:0]        tbl_waddr;

	function automatic logic [IdxW-1:0] encode(input logic [TABLE_ENTRIES-1:0] oh);
		logic [IdxW-1:0] idx;
		idx = '0;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			if (oh[i]) begin
				idx = idx | IdxW'(i);
			end
		end
		return idx;
	endfunction

	always_comb begin
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			match[i] = valid_q[i] && (key_q[i] == job_q.state_address);
		end
		free      = ~valid_q;
		// Isolate the lowest free slot so the encoder sees a single bit.
		free_low  = free & (~free + TABLE_ENTRIES'(1));
		match_idx = encode(match);
		free_idx  = encode(free_low);
	end

	assign pop       = (state_q == S_IDLE) && head.valid;
	assign load      = (state_q == S_EMIT) && (!out_valid || out_ready);
	assign prev      = hit_q ? ram_rdata : 32'd0;
	assign init      = |(job_q.flags & adcsm_pkg::INIT_FLAG);
	assign tbl_we    = load && (job_q.book != 32'd0) && (hit_q || free_any_q);
	assign tbl_waddr = hit_q ? hit_idx_q : free_idx_q;

	adcsm_ram #(
		.WIDTH(32),
		.DEPTH(TABLE_ENTRIES)
	) u_book_ram (
		.clk  (clk),
		.we   (tbl_we),
		.waddr(tbl_waddr),
		.wdata(job_q.book),
		.re   (state_q == S_READ),
		.raddr(hit_idx_q),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			valid_q   <= '0;
			event_q   <= '0;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && out_ready && !load) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (head.valid) begin
						state_q <= S_MATCH;
					end
				end
				S_MATCH: begin
					state_q <= S_READ;
				end
				S_READ: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (load) begin
						out_valid <= 1'b1;
						event_q   <= event_q + 32'd1;
						state_q   <= S_IDLE;
						if (tbl_we && !hit_q) begin
							valid_q[free_idx_q] <= 1'b1;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Payload registers carry no reset.
	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= head.job;
		end
		if (state_q == S_MATCH) begin
			match_q    <= match;
			hit_q      <= |match;
			hit_idx_q  <= match_idx;
			free_any_q <= |free;
			free_idx_q <= free_idx;
		end
		if (tbl_we && !hit_q) begin
			key_q[free_idx_q] <= job_q.state_address;
		end
		if (load) begin
			event_index   <= event_q;
			list_number   <= job_q.list_number;
			state_address <= job_q.state_address;
			book_address  <= job_q.book;
			previous_book <= prev;
			decode_flags  <= job_q.flags;
			init_bit      <= init;
			sample_count  <= job_q.count;
			suspect       <= (prev != 32'd0) && (job_q.book != 32'd0) &&
				(job_q.book != prev) && !init;
		end
	end

	// Keys stay unique among valid entries, so a lookup hits at most one slot.
	a_match_unique: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_READ) |-> $onehot0(match_q))
		else $error("table lookup hit more than one entry");

	a_event_step: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (event_q == $past(event_q) + 32'd1))
		else $error("event counter did not advance with an emitted event");

	a_valid_grows: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) >= $past($countones(valid_q)))
		else $error("a table entry lost its valid bit");

	a_suspect_init: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(suspect && init_bit))
		else $error("suspect flagged on an init decode");

endmodule

`default_nettype wire

// ----- design/adpcm_command_stream_monitor.sv -----
// Top level of the ADPCM command stream monitor: front, queue and back.
// Depends on adcsm_pkg, adcsm_front, adcsm_queue, adcsm_back, adcsm_ram.
//
//   Channel   Handshake               Beat contents
//   input     in_valid / in_ready     first_in_list, word_high, word_low
//   output    out_valid / out_ready   event_index .. suspect (one decode event)
//   config    cfg_we                  cfg_wdata -> max_commands
//
// The front takes one input beat per cycle while the job queue has room;
// commands other than decodes finish in that cycle.
// Each decode passes through four steps in the back part (take job, table compare,
// book RAM read, emit), set by the table lookup and the RAM's registered read.
// Reset clears all valid bits and counters at once; no clearing pass is run.
// A stalled output holds the back part, which fills the queue and then
// lowers in_ready.
`default_nettype none

module adpcm_command_stream_monitor #(
	parameter int unsigned TABLE_ENTRIES = adcsm_pkg::TableEntries
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        first_in_list,
	input  wire logic [31:0] word_high,
	input  wire logic [31:0] word_low,
	input  wire logic        cfg_we,
	input  wire logic [13:0] cfg_wdata,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      event_index,
	output logic [31:0]      list_number,
	output logic [23:0]      state_address,
	output logic [31:0]      book_address,
	output logic [31:0]      previous_book,
	output logic [3:0]       decode_flags,
	output logic             init_bit,
	output logic [11:0]      sample_count,
	output logic             suspect
);

	adcsm_pkg::job_beat_t job_push;
	adcsm_pkg::job_beat_t job_head;
	logic                 q_full;
	logic                 q_pop;

	adcsm_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.first_in_list(first_in_list),
		.word_high    (word_high),
		.word_low     (word_low),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.q_full       (q_full),
		.job_push     (job_push)
	);

	adcsm_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (job_push),
		.full  (q_full),
		.pop   (q_pop),
		.head  (job_head)
	);

	adcsm_back #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (job_head),
		.pop          (q_pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.event_index  (event_index),
		.list_number  (list_number),
		.state_address(state_address),
		.book_address (book_address),
		.previous_book(previous_book),
		.decode_flags (decode_flags),
		.init_bit     (init_bit),
		.sample_count (sample_count),
		.suspect      (suspect)
	);

endmodule

`default_nettype wire
